### hw/rtl/huffman_code_bit_packer_core_defines.svh
// Assertion macros shared by the bit packer RTL.
// Define ASSERT_OFF to compile every check to nothing.
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// checked only outside reset
`define HCBP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define HCBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCBP_ASSERT(lbl, clk, rst, prop, msg)
`define HCBP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/hcbp_pkg.sv
`timescale 1ns / 1ps
// Types and constants of the Huffman code bit packer.
// No dependencies; used by the core and the testbench.
package hcbp_pkg;

   localparam int unsigned WORD_W = 16;
   localparam int unsigned DWORD_W = 2 * WORD_W;
   localparam int unsigned CODE_W = 16;
   localparam int unsigned LEN_W = 5;
   localparam int unsigned SYM_W = 8;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FINISH = 2'd2
   } op_type;

   typedef struct packed {
      op_type             operation;
      logic [SYM_W-1:0]   symbol;
      logic [CODE_W-1:0]  code_bits;
      logic [LEN_W-1:0]   code_length;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]  packed_word;
      logic [LEN_W-1:0]   valid_bits;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [LEN_W-1:0]   length;
   } entry_type;

endpackage

### hw/rtl/hcbp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hcbp_ram #(
   parameter int unsigned WIDTH = 21,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/huffman_code_bit_packer_core.sv
`timescale 1ns / 1ps
// Huffman code bit packer: code table in hcbp_ram, accumulator in flops.
// Depends on hcbp_pkg, hcbp_ram and huffman_code_bit_packer_core_defines.svh.

// Takes one item per cycle while not stalled. A load writes the code table at
// the edge that accepts it. An encode reads the table into the registered read
// port at its accept edge; when the merge stage advances, it merges the code into
// the 16-bit accumulator, and a filled word is loaded into the output register
// at that same edge, from which it leaves once the output is not stalled.
// A finish flushes the partial word with last set and clears the
// accumulator. The single read port of the table and the accumulator update
// set the rate at one item per cycle; input stalls only while the output
// register is full and held. The table has no reset and no clearing pass:
// encode only symbols whose entry was loaded.
module huffman_code_bit_packer_core
   import hcbp_pkg::*;
#(
   parameter int unsigned ALPHABET_SIZE = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

`include "huffman_code_bit_packer_core_defines.svh"

   localparam int unsigned ADDR_W = $clog2(ALPHABET_SIZE);

   logic                req_fire;
   logic                sym_in_range;
   logic                adv;
   logic                s1_fire;
   logic [LEN_W-1:0]    load_len;
   entry_type           wr_entry;
   entry_type           rd_entry;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_finish_ff, s1_finish_in;
   logic [WORD_W-1:0]   acc_ff, acc_in;
   logic [LEN_W-1:0]    fill_ff, fill_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [LEN_W-1:0]    len_eff;
   logic [CODE_W-1:0]   code_eff;
   logic [DWORD_W-1:0]  wide;
   logic [LEN_W:0]      total;
   logic [LEN_W-1:0]    spill;
   logic                emit;

   assign req_fire     = req_valid && !req_stall;
   assign sym_in_range = ({1'b0, req_data.symbol} < (SYM_W+1)'(ALPHABET_SIZE));
   assign adv          = !rsp_valid_ff || !rsp_stall;
   assign s1_fire      = s1_valid_ff && adv;
   assign req_stall    = s1_valid_ff && !adv;

   // saturate overlong lengths on load
   assign load_len = (req_data.code_length > LEN_W'(WORD_W)) ?
                     LEN_W'(WORD_W) : req_data.code_length;
   assign wr_entry = '{code: req_data.code_bits, length: load_len};

   hcbp_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (ALPHABET_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (req_fire && req_data.operation == OP_LOAD && sym_in_range),
      .wr_addr (req_data.symbol[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (req_fire && req_data.operation == OP_ENCODE && sym_in_range),
      .rd_addr (req_data.symbol[ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   // only encodes of valid symbols and finishes enter the merge stage
   always_comb begin
      s1_valid_in  = s1_valid_ff && !s1_fire;
      s1_finish_in = s1_finish_ff;
      if (req_fire) begin
         unique case (req_data.operation)
            OP_ENCODE: begin
               s1_valid_in  = sym_in_range;
               s1_finish_in = 1'b0;
            end
            OP_FINISH: begin
               s1_valid_in  = 1'b1;
               s1_finish_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // merge: append the code below the held bits, split when it overflows
   always_comb begin
      len_eff  = (rd_entry.length > LEN_W'(WORD_W)) ? LEN_W'(WORD_W) : rd_entry.length;
      code_eff = rd_entry.code & ~({CODE_W{1'b1}} << len_eff);
      wide     = (DWORD_W'(acc_ff) << len_eff) | DWORD_W'(code_eff);
      total    = {1'b0, fill_ff} + {1'b0, len_eff};
      spill    = LEN_W'(total - (LEN_W+1)'(WORD_W));
      emit     = 1'b0;
      acc_in   = acc_ff;
      fill_in  = fill_ff;
      rsp_data_in = rsp_data_ff;
      if (s1_fire) begin
         if (s1_finish_ff) begin
            emit = 1'b1;
            rsp_data_in.packed_word = acc_ff << (LEN_W'(WORD_W) - fill_ff);
            rsp_data_in.valid_bits  = fill_ff;
            rsp_data_in.last        = 1'b1;
            acc_in  = '0;
            fill_in = '0;
         end else if (total <= (LEN_W+1)'(WORD_W)) begin
            acc_in  = wide[WORD_W-1:0];
            fill_in = total[LEN_W-1:0];
         end else begin
            emit = 1'b1;
            rsp_data_in.packed_word = WORD_W'(wide >> spill);
            rsp_data_in.valid_bits  = LEN_W'(WORD_W);
            rsp_data_in.last        = 1'b0;
            acc_in  = wide[WORD_W-1:0] & ~({WORD_W{1'b1}} << spill);
            fill_in = spill;
         end
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         acc_ff       <= acc_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_finish_ff <= s1_finish_in;
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `HCBP_ASSERT(a_fill_bound, clock, reset, fill_ff <= LEN_W'(WORD_W), "fill count above word width")
   `HCBP_ASSERT(a_acc_clean, clock, reset, (acc_ff >> fill_ff) == '0, "accumulator bits above fill count")
   `HCBP_ASSERT(a_full_word, clock, reset, rsp_valid_ff && !rsp_data_ff.last |-> rsp_data_ff.valid_bits == LEN_W'(WORD_W), "encode word not full")
   `HCBP_ASSERT(a_finish_clears, clock, reset, s1_fire && s1_finish_ff |=> fill_ff == '0 && acc_ff == '0, "finish left bits behind")
   `HCBP_ASSERT_ALWAYS(a_stall_cause, clock, req_stall |-> s1_valid_ff && rsp_valid_ff, "input stalled without a held result")

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for huffman_code_bit_packer_core: a directed table of beats,
// then random beats of every opcode, checked against an in-bench packer model.
// Depends on hcbp_pkg and the core RTL; drives both channels with random idle cycles.
module tb_top;
   import hcbp_pkg::*;

   localparam int unsigned CLK_PERIOD   = 20;
   localparam int unsigned RAND_ITEMS   = 2000;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam logic [1:0]  OP_RESERVED  = 2'd3;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // packer model state
   logic [CODE_W-1:0] code_mem [256];
   logic [LEN_W-1:0]  len_mem  [256];
   logic [WORD_W-1:0] acc_bits = '0;
   int unsigned       acc_fill = 0;

   bit                loaded_flag [256];
   logic [SYM_W-1:0]  loaded_syms [$];
   rsp_type           expected_words [$];
   row_type           directed_rows [$];
   int unsigned       errors      = 0;
   int unsigned       cycle_count = 0;
   bit                quiet       = 1'b0;

   huffman_code_bit_packer_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Advance the packer model by one accepted beat; returns 1 when a word leaves.
   function automatic bit pack_code(input req_type item, output rsp_type word);
      int unsigned len;
      int unsigned room;
      int unsigned spill;
      logic [31:0] code;
      word = '0;
      case (item.operation)
         OP_LOAD: begin
            len = item.code_length;
            if (len > WORD_W) len = WORD_W;
            code_mem[item.symbol] = item.code_bits;
            len_mem[item.symbol]  = LEN_W'(len);
            return 1'b0;
         end
         OP_ENCODE: begin
            len  = len_mem[item.symbol];
            code = 32'(code_mem[item.symbol]) & ((32'd1 << len) - 32'd1);
            if (acc_fill + len <= WORD_W) begin
               acc_bits = WORD_W'((32'(acc_bits) << len) | code);
               acc_fill += len;
               return 1'b0;
            end
            // split: top bits close the word, low bits start the next one
            room  = WORD_W - acc_fill;
            spill = len - room;
            word.packed_word = WORD_W'((32'(acc_bits) << room) | (code >> spill));
            word.valid_bits  = LEN_W'(WORD_W);
            word.last        = 1'b0;
            acc_bits = WORD_W'(code & ((32'd1 << spill) - 32'd1));
            acc_fill = spill;
            return 1'b1;
         end
         OP_FINISH: begin
            word.packed_word = WORD_W'(32'(acc_bits) << (WORD_W - acc_fill));
            word.valid_bits  = LEN_W'(acc_fill);
            word.last        = 1'b1;
            acc_bits = '0;
            acc_fill = 0;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void add_row(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                                   input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                                   input bit typed = 1'b0, input logic [WORD_W-1:0] word = '0,
                                   input logic [LEN_W-1:0] bits = '0, input logic last = 1'b0);
      row_type row;
      row.item.operation   = op_type'(op);
      row.item.symbol      = sym;
      row.item.code_bits   = code;
      row.item.code_length = len;
      row.typed            = typed;
      row.want.packed_word = word;
      row.want.valid_bits  = bits;
      row.want.last        = last;
      directed_rows.push_back(row);
   endfunction

   // Present one beat, hold it until accepted, then record what it should produce.
   task automatic send_beat(input req_type item, input bit typed, input rsp_type want);
      rsp_type word;
      if (!quiet && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (item.operation == OP_LOAD && !loaded_flag[item.symbol]) begin
         loaded_flag[item.symbol] = 1'b1;
         loaded_syms.push_back(item.symbol);
      end
      if (pack_code(item, word)) expected_words.push_back(typed ? want : word);
   endtask

   always @(posedge clock) begin : check_words
      rsp_type want;
      cycle_count <= cycle_count + 1;
      rsp_stall   <= !quiet && ($urandom_range(0, 99) < 14);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual %h/%0d/%0d", $time,
                     rsp_data.packed_word, rsp_data.valid_bits, rsp_data.last);
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.packed_word !== want.packed_word) begin
               errors++;
               $display("%0t: packed_word expected %h actual %h", $time,
                        want.packed_word, rsp_data.packed_word);
            end
            if (rsp_data.valid_bits !== want.valid_bits) begin
               errors++;
               $display("%0t: valid_bits expected %0d actual %0d", $time,
                        want.valid_bits, rsp_data.valid_bits);
            end
            if (rsp_data.last !== want.last) begin
               errors++;
               $display("%0t: last expected %0d actual %0d", $time, want.last, rsp_data.last);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      req_type     item;
      rsp_type     none;
      int unsigned sel;
      none = '0;

      add_row(OP_FINISH, 8'h00, 16'h0000, 5'd0, 1'b1, 16'h0000, 5'd0, 1'b1); // empty flush
      add_row(OP_LOAD, 8'h00, 16'hFFFF, 5'd16);
      add_row(OP_LOAD, 8'hFF, 16'h0001, 5'd1);
      add_row(OP_LOAD, 8'h01, 16'hFFFF, 5'd3);   // code wider than its length
      add_row(OP_LOAD, 8'h02, 16'h0000, 5'd31);  // overlong length saturates
      add_row(OP_LOAD, 8'h03, 16'h1234, 5'd0);   // zero-length code
      add_row(OP_RESERVED, 8'hAA, 16'h5555, 5'h15);
      add_row(OP_ENCODE, 8'h00, 16'h0000, 5'd0); // fills the word exactly
      add_row(OP_ENCODE, 8'h03, 16'hFFFF, 5'd31);
      add_row(OP_ENCODE, 8'hFF, 16'h0000, 5'd0, 1'b1, 16'hFFFF, 5'd16, 1'b0);
      add_row(OP_FINISH, 8'h00, 16'h0000, 5'd0, 1'b1, 16'h8000, 5'd1, 1'b1);
      repeat (5) add_row(OP_ENCODE, 8'h01, 16'h0000, 5'd0);
      add_row(OP_ENCODE, 8'h01, 16'h0000, 5'd0); // splits across words
      add_row(OP_ENCODE, 8'h02, 16'h0000, 5'd0);
      add_row(OP_FINISH, 8'h00, 16'h0000, 5'd0);
      add_row(OP_LOAD, 8'h80, 16'hA5C3, 5'd16);
      add_row(OP_ENCODE, 8'h80, 16'h0000, 5'd0);
      add_row(OP_ENCODE, 8'h80, 16'h0000, 5'd0, 1'b1, 16'hA5C3, 5'd16, 1'b0);
      add_row(OP_FINISH, 8'h00, 16'h0000, 5'd0, 1'b1, 16'hA5C3, 5'd16, 1'b1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      for (int n = 0; n < RAND_ITEMS; n++) begin
         quiet = (n >= 800 && n < 1100);
         if (n == 1500) begin
            // hold off until the output side has drained
            req_valid <= 1'b0;
            @(posedge clock);
            while (expected_words.size() != 0) @(posedge clock);
         end
         sel = $urandom_range(0, 99);
         item.symbol      = SYM_W'($urandom);
         item.code_bits   = CODE_W'($urandom);
         item.code_length = LEN_W'($urandom);
         if (loaded_syms.size() == 0 || sel < 14) begin
            item.operation = OP_LOAD;
            if ($urandom_range(0, 9) != 0)
               item.code_length = LEN_W'($urandom_range(1, WORD_W));
         end else if (sel < 21) begin
            item.operation = OP_FINISH;
         end else if (sel < 24) begin
            item.operation = op_type'(OP_RESERVED);
         end else begin
            item.operation = OP_ENCODE;
            item.symbol    = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
         end
         send_beat(item, 1'b0, none);
      end

      req_valid <= 1'b0;
      quiet = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
